/* design/bchd_pkg.sv */
// Shared types and constants for the button click / hold detector.
// Holds the phase and event encodings, the register map and the settings record.
// No dependencies; every other design file imports this package.
package bchd_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int TICK_W         = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int EVENT_W        = 3;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_PRESS        = 4'd1,
    PH_WAIT_SINGLE  = 4'd2,
    PH_WAIT_DOUBLE  = 4'd3,
    PH_WAIT_HOLD    = 4'd4,
    PH_WAIT_RELEASE = 4'd5,
    PH_SINGLE       = 4'd6,
    PH_DOUBLE       = 4'd7,
    PH_HOLD         = 4'd8,
    PH_RELEASE      = 4'd9
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_SINGLE  = 3'd1,
    EV_DOUBLE  = 3'd2,
    EV_HOLD    = 3'd3,
    EV_RELEASE = 3'd4
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_LEVEL  = 3'd0,
    REG_DEBOUNCE     = 3'd1,
    REG_CLICK        = 3'd2,
    REG_RELEASE_GAP  = 3'd3,
    REG_HOLD         = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              press_level;
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] click_ticks;
    logic [TICK_W-1:0] release_gap_ticks;
    logic [TICK_W-1:0] hold_ticks;
  } cfg_t;

  localparam logic              RST_PRESS_LEVEL  = 1'b1;
  localparam logic [TICK_W-1:0] RST_DEBOUNCE     = 16'd50;
  localparam logic [TICK_W-1:0] RST_CLICK        = 16'd500;
  localparam logic [TICK_W-1:0] RST_RELEASE_GAP  = 16'd300;
  localparam logic [TICK_W-1:0] RST_HOLD         = 16'd1000;

endpackage

/* design/button_click_hold_detector.sv */
// Button click, double click, hold and release detector, one beat per tick.
// Path: an input beat accepted into the step register is evaluated against the
// state and lands in the result register when it is stepped.
// Throughput: one beat per cycle while the result side is not stalled.
// Reset (rst, synchronous, active high) restores the register reset values and
// clears the phase machine, the debounce logic and both pipeline registers.
module button_click_hold_detector #(
  parameter int COUNT_BITS = bchd_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input tick channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           pin_level,
  input  logic                           edge_seen,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bchd_pkg::EVENT_W-1:0]   event_code,
  // Register write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bchd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bchd_pkg::TICK_W-1:0]    cfg_data
);
  import bchd_pkg::*;

  // Register file. Writes are taken every cycle; unknown indexes are dropped.
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_level       <= RST_PRESS_LEVEL;
      cfg.debounce_ticks    <= RST_DEBOUNCE;
      cfg.click_ticks       <= RST_CLICK;
      cfg.release_gap_ticks <= RST_RELEASE_GAP;
      cfg.hold_ticks        <= RST_HOLD;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_PRESS_LEVEL:  cfg.press_level       <= cfg_data[0];
        REG_DEBOUNCE:     cfg.debounce_ticks    <= cfg_data;
        REG_CLICK:        cfg.click_ticks       <= cfg_data;
        REG_RELEASE_GAP:  cfg.release_gap_ticks <= cfg_data;
        REG_HOLD:         cfg.hold_ticks        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Step register: holds one accepted tick until the result register can take
  // its event. The state machines advance exactly when this beat moves on.
  logic s1_valid;
  logic s1_pin;
  logic s1_edge;
  logic s1_advance;
  logic step;

  assign s1_advance = !out_valid || !out_stall;
  assign step       = s1_valid && s1_advance;
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_pin  <= pin_level;
      s1_edge <= edge_seen;
    end
  end

  // Debounce first; the phase machine sees the level sampled on this tick.
  logic                 level_now;
  logic                 pressed;
  logic [EVENT_W-1:0]   event_next;

  bchd_debounce #(
    .COUNT_BITS (COUNT_BITS)
  ) u_debounce (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .pin_level      (s1_pin),
    .edge_seen      (s1_edge),
    .debounce_ticks (cfg.debounce_ticks),
    .level_now      (level_now)
  );

  assign pressed = (level_now == cfg.press_level);

  bchd_phase_fsm #(
    .COUNT_BITS (COUNT_BITS)
  ) u_phase_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .pressed    (pressed),
    .cfg        (cfg),
    .event_next (event_next)
  );

  // Result register. It refills in the same cycle its beat is taken, so the
  // input side keeps flowing while the output side takes every beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      event_code <= event_next;
    end
  end

  // An empty result register never holds back the input side.
  a_no_stall_when_empty: assert property (
    @(posedge clk) disable iff (rst) !out_valid |-> !in_stall
  ) else $error("input stalled while the result register was empty");

  // A new result only appears after a tick was stepped.
  a_result_from_step: assert property (
    @(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(step)
  ) else $error("result appeared without a stepped tick");

  // A tick parked in the step register keeps its pin sample until stepped.
  a_step_reg_holds: assert property (
    @(posedge clk) disable iff (rst)
      (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_pin) && $stable(s1_edge))
  ) else $error("parked tick lost or changed");

  // The event register keeps its value while the result is held by a stall.
  a_event_only_on_step: assert property (
    @(posedge clk) disable iff (rst)
      (out_valid && out_stall) |=> $stable(event_code)
  ) else $error("event changed while the result was held");

endmodule

/* design/bchd_debounce.sv */
// Debounce stage: saturating debounce timer, debouncing flag and debounced level.
// Depends on bchd_pkg for the tick width.
module bchd_debounce #(
  parameter int COUNT_BITS = bchd_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        pin_level,
  input  logic                        edge_seen,
  input  logic [bchd_pkg::TICK_W-1:0] debounce_ticks,
  output logic                        level_now
);
  import bchd_pkg::*;

  localparam int CMP_W = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;

  logic                  debouncing;
  logic                  debouncing_next;
  logic                  level;
  logic [COUNT_BITS-1:0] elapsed;
  logic [COUNT_BITS-1:0] elapsed_next;
  logic                  busy_mid;
  logic [COUNT_BITS-1:0] elapsed_inc;

  // The timer advances first, then an edge seen while not debouncing restarts it,
  // then the pin is sampled once the interval is over.
  always_comb begin
    elapsed_inc = (elapsed == {COUNT_BITS{1'b1}}) ? elapsed : elapsed + 1'b1;
    busy_mid     = debouncing;
    elapsed_next = elapsed_inc;
    if (edge_seen && !debouncing) begin
      busy_mid     = 1'b1;
      elapsed_next = '0;
    end
    debouncing_next = busy_mid;
    level_now       = level;
    if (busy_mid && (CMP_W'(elapsed_next) >= CMP_W'(debounce_ticks))) begin
      level_now       = pin_level;
      debouncing_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debouncing <= 1'b0;
      level      <= 1'b0;
      elapsed    <= '0;
    end else if (step) begin
      debouncing <= debouncing_next;
      level      <= level_now;
      elapsed    <= elapsed_next;
    end
  end

endmodule

/* design/bchd_phase_fsm.sv */
// Phase machine: turns the debounced press state and the phase timer into events.
// Depends on bchd_pkg for the phase, event and settings types.
module bchd_phase_fsm #(
  parameter int COUNT_BITS = bchd_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         pressed,
  input  bchd_pkg::cfg_t               cfg,
  output logic [bchd_pkg::EVENT_W-1:0] event_next
);
  import bchd_pkg::*;

  localparam int CMP_W = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;

  phase_t                phase;
  phase_t                phase_next;
  logic [COUNT_BITS-1:0] elapsed;
  logic [COUNT_BITS-1:0] elapsed_next;
  logic [COUNT_BITS-1:0] elapsed_inc;
  logic                  past_click;
  logic                  past_gap;
  logic                  past_hold;
  event_t                ev;

  always_comb begin
    elapsed_inc = (elapsed == {COUNT_BITS{1'b1}}) ? elapsed : elapsed + 1'b1;
    past_click  = CMP_W'(elapsed_inc) >= CMP_W'(cfg.click_ticks);
    past_gap    = CMP_W'(elapsed_inc) >= CMP_W'(cfg.release_gap_ticks);
    past_hold   = CMP_W'(elapsed_inc) >= CMP_W'(cfg.hold_ticks);
    phase_next   = phase;
    elapsed_next = elapsed_inc;
    ev           = EV_NONE;
    case (phase)
      PH_IDLE: begin
        if (pressed) begin
          phase_next   = PH_PRESS;
          elapsed_next = '0;
        end
      end
      PH_PRESS: begin
        if (!pressed) begin
          if (!past_click) begin
            phase_next   = PH_WAIT_SINGLE;
            elapsed_next = '0;
          end else begin
            phase_next = PH_IDLE;
          end
        end else if (past_click) begin
          phase_next = PH_WAIT_HOLD;
        end
      end
      PH_WAIT_SINGLE: begin
        // A button still down after the gap keeps waiting for its release.
        if (past_gap) begin
          if (!pressed) begin
            phase_next = PH_SINGLE;
          end
        end else if (pressed) begin
          phase_next   = PH_WAIT_DOUBLE;
          elapsed_next = '0;
        end
      end
      PH_WAIT_DOUBLE: begin
        if (!pressed) begin
          phase_next = past_click ? PH_IDLE : PH_DOUBLE;
        end else if (past_click) begin
          phase_next = PH_IDLE;
        end
      end
      PH_WAIT_HOLD: begin
        if (past_hold) begin
          phase_next = pressed ? PH_HOLD : PH_IDLE;
        end
      end
      PH_WAIT_RELEASE: begin
        if (!pressed && past_gap) begin
          phase_next = PH_RELEASE;
        end
      end
      PH_SINGLE: begin
        phase_next = PH_IDLE;
        ev         = EV_SINGLE;
      end
      PH_DOUBLE: begin
        phase_next = PH_IDLE;
        ev         = EV_DOUBLE;
      end
      PH_HOLD: begin
        phase_next   = PH_WAIT_RELEASE;
        elapsed_next = '0;
        ev           = EV_HOLD;
      end
      PH_RELEASE: begin
        phase_next = PH_IDLE;
        ev         = EV_RELEASE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    event_next = ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      elapsed <= '0;
    end else if (step) begin
      phase   <= phase_next;
      elapsed <= elapsed_next;
    end
  end

endmodule
